FILE: sv/sgrt_pkg.sv
// ----------------------------------------------------------------------------
// sgrt_pkg
// Shared types, field widths, codes and control structs of the slot region
// table.
// ----------------------------------------------------------------------------
package sgrt_pkg;

    localparam int SLOTS_DEF    = 64;
    localparam int GEN_BITS_DEF = 16;

    localparam int KIND_W      = 3;
    localparam int IDX_FW      = 6;
    localparam int GEN_FW      = 16;
    localparam int CNT_FW      = 7;
    localparam int IN_TDATA_W  = 272;
    localparam int OUT_TDATA_W = 208;

    localparam logic [KIND_W-1:0] KIND_ADD     = 3'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_GET     = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESOLVE = 3'd4;

    // layout matches tdata bits 200:22
    typedef struct packed {
        logic signed [31:0] level;
        logic signed [15:0] prio;
        logic signed [31:0] max_z;
        logic signed [31:0] max_x;
        logic signed [31:0] min_z;
        logic signed [31:0] min_x;
        logic        [2:0]  flags;
    } rec_t;

    typedef enum logic [1:0] {
        RD_ITEM = 2'd0,
        RD_SCAN = 2'd1,
        RD_BEST = 2'd2
    } rd_src_t;

    typedef enum logic [2:0] {
        RES_FAIL    = 3'd0,
        RES_ACK     = 3'd1,
        RES_ADD     = 3'd2,
        RES_GET     = 3'd3,
        RES_RESOLVE = 3'd4
    } res_sel_t;

    typedef struct packed {
        logic     cap;
        logic     cnt_clr;
        logic     cnt_inc;
        logic     best_clr;
        logic     rd_en;
        rd_src_t  rd_src;
        logic     scan_push;
        logic     wr_add;
        logic     wr_upd;
        logic     wr_rem;
        logic     res_ld;
        res_sel_t res_sel;
    } cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              live;
        logic              full;
        logic              scan_free;
        logic              scan_last;
        logic              pipe_busy;
        logic              out_free;
    } sts_t;

endpackage

FILE: sv/generational_slot_region_table_unit.sv
// ----------------------------------------------------------------------------
// generational_slot_region_table_unit
// Generational slot table of water regions with add, update, remove, get and
// point resolve, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Input channel s_axis: tuser carries the kind, tdata the handle, the region
// record and the query point. Output channel m_axis: tuser is the ok flag,
// tdata the returned handle, record and live count. Every input transaction
// gives exactly one result transaction.
// Steps per item: update, remove and get read the handle's slot, then check and
// act. Add walks the occupied marks one slot a cycle from slot 0 up to the
// lowest free one; a full table fails without a walk.
// Resolve reads one slot a cycle from the record memory through a three stage
// compare pipeline, then reads back the best slot's generation. The slot
// memories have a single read port.
// Items are taken one at a time; s_axis_tready is high only while idle, and a
// result waiting in the output register does not hold off the next input.
// Under backpressure on m_axis the block finishes its work and waits with the
// table unchanged until the output register frees.
// Reset empties the table at once (all marks clear, all generations one);
// the record memories need no clearing.
// ----------------------------------------------------------------------------
module generational_slot_region_table_unit #(
    parameter int SLOTS    = sgrt_pkg::SLOTS_DEF,
    parameter int GEN_BITS = sgrt_pkg::GEN_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // slot_index, generation, body_flags, min_x, min_z, max_x, max_z,
    // priority_req, surface_level, point_x, point_z, zero pad
    input  logic [sgrt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [sgrt_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // out_index, out_generation, out_flags, out_min_x, out_min_z, out_max_x,
    // out_max_z, out_priority, out_level, live_count
    output logic [sgrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // ok
    output logic                             m_axis_tuser
);
    import sgrt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    sgrt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .s_tuser  (s_axis_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    sgrt_datapath #(
        .SLOTS    (SLOTS),
        .GEN_BITS (GEN_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_axis_tdata),
        .s_tuser  (s_axis_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .m_tdata  (m_axis_tdata),
        .m_tuser  (m_axis_tuser)
    );

    // live count never exceeds the table size
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (32'(m_axis_tdata[207:201]) <= SLOTS))
        else $error("live count above table size");

    // a failed transaction carries nothing but the live count
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[200:0] == '0))
        else $error("failed result with payload");

    // one item at a time: after an accept the input side closes
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while busy");

    // a result is loaded only when the output register is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_ld |-> sts.out_free)
        else $error("result register overwritten");

endmodule

FILE: sv/sgrt_ctrl.sv
// ----------------------------------------------------------------------------
// sgrt_ctrl
// Controller: sequences handle checks, the free slot search and the resolve
// scan, and hands results to the output register.
// ----------------------------------------------------------------------------
module sgrt_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [sgrt_pkg::KIND_W-1:0] s_tuser,
    input  sgrt_pkg::sts_t            sts,
    output sgrt_pkg::cmd_t            cmd
);
    import sgrt_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE      = 10'b00_0000_0001,
        ST_LOOK      = 10'b00_0000_0010,
        ST_CHECK     = 10'b00_0000_0100,
        ST_ADD_SCAN  = 10'b00_0000_1000,
        ST_ADD_WRITE = 10'b00_0001_0000,
        ST_RES_SCAN  = 10'b00_0010_0000,
        ST_RES_DRAIN = 10'b00_0100_0000,
        ST_RES_GEN   = 10'b00_1000_0000,
        ST_RES_FIN   = 10'b01_0000_0000,
        ST_FAIL      = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.cap      = 1'b1;
                    cmd.cnt_clr  = 1'b1;
                    cmd.best_clr = 1'b1;
                    case (s_tuser)
                        KIND_ADD:     state_next = ST_ADD_SCAN;
                        KIND_UPDATE:  state_next = ST_LOOK;
                        KIND_REMOVE:  state_next = ST_LOOK;
                        KIND_GET:     state_next = ST_LOOK;
                        KIND_RESOLVE: state_next = ST_RES_SCAN;
                        default:      state_next = ST_FAIL;
                    endcase
                end
            end
            ST_LOOK: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_ITEM;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.out_free) begin
                    cmd.res_ld = 1'b1;
                    cmd.res_sel = RES_FAIL;
                    if (sts.live) begin
                        case (sts.kind)
                            KIND_UPDATE: begin
                                cmd.wr_upd  = 1'b1;
                                cmd.res_sel = RES_ACK;
                            end
                            KIND_REMOVE: begin
                                cmd.wr_rem  = 1'b1;
                                cmd.res_sel = RES_ACK;
                            end
                            KIND_GET: cmd.res_sel = RES_GET;
                            default:  cmd.res_sel = RES_FAIL;
                        endcase
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_ADD_SCAN: begin
                if (sts.full) begin
                    state_next = ST_FAIL;
                end else if (sts.scan_free) begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RD_SCAN;
                    state_next = ST_ADD_WRITE;
                end else begin
                    cmd.cnt_inc = 1'b1;
                end
            end
            ST_ADD_WRITE: begin
                if (sts.out_free) begin
                    cmd.wr_add  = 1'b1;
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = RES_ADD;
                    state_next  = ST_IDLE;
                end
            end
            ST_RES_SCAN: begin
                cmd.rd_en     = 1'b1;
                cmd.rd_src    = RD_SCAN;
                cmd.scan_push = 1'b1;
                cmd.cnt_inc   = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_RES_DRAIN;
                end
            end
            ST_RES_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_RES_GEN;
                end
            end
            ST_RES_GEN: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_BEST;
                state_next = ST_RES_FIN;
            end
            ST_RES_FIN: begin
                if (sts.out_free) begin
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = RES_RESOLVE;
                    state_next  = ST_IDLE;
                end
            end
            ST_FAIL: begin
                if (sts.out_free) begin
                    cmd.res_ld  = 1'b1;
                    cmd.res_sel = RES_FAIL;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/sgrt_datapath.sv
// ----------------------------------------------------------------------------
// sgrt_datapath
// Datapath: item register, slot memories, occupancy, scan pipeline with the
// best-region tracker, and the result register.
// ----------------------------------------------------------------------------
module sgrt_datapath #(
    parameter int SLOTS    = sgrt_pkg::SLOTS_DEF,
    parameter int GEN_BITS = sgrt_pkg::GEN_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [sgrt_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic [sgrt_pkg::KIND_W-1:0]      s_tuser,
    input  sgrt_pkg::cmd_t                   cmd,
    output sgrt_pkg::sts_t                   sts,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sgrt_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tuser
);
    import sgrt_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // item register
    logic [KIND_W-1:0]  kind_reg;
    logic [IDX_FW-1:0]  idx_reg;
    logic [GEN_FW-1:0]  gen_reg;
    rec_t               rec_in_reg;
    logic signed [31:0] px_reg, pz_reg;

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            kind_reg   <= s_tuser;
            idx_reg    <= s_tdata[5:0];
            gen_reg    <= s_tdata[21:6];
            rec_in_reg <= rec_t'(s_tdata[200:22]);
            px_reg     <= $signed(s_tdata[232:201]);
            pz_reg     <= $signed(s_tdata[264:233]);
        end
    end

    logic             in_range;
    logic [IDX_W-1:0] item_addr;
    assign in_range  = (32'(idx_reg) < SLOTS);
    assign item_addr = in_range ? IDX_W'(idx_reg) : '0;

    // scan counter
    logic [IDX_W-1:0] cnt_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_clr) begin
            cnt_reg <= '0;
        end else if (cmd.cnt_inc) begin
            cnt_reg <= (cnt_reg == LAST_IDX) ? '0 : cnt_reg + 1'b1;
        end
    end

    // occupancy, generation valid bits and live count
    logic [SLOTS-1:0] occ_reg;
    logic [SLOTS-1:0] gvalid_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    logic [IDX_W-1:0] best_idx_reg;
    logic [IDX_W-1:0] rd_addr;
    always_comb begin
        case (cmd.rd_src)
            RD_ITEM: rd_addr = item_addr;
            RD_SCAN: rd_addr = cnt_reg;
            RD_BEST: rd_addr = best_idx_reg;
            default: rd_addr = cnt_reg;
        endcase
    end

    // slot memories
    rec_t                rec_mem [SLOTS];
    logic [GEN_BITS-1:0] gen_mem [SLOTS];
    rec_t                rd_rec_reg;
    logic [GEN_BITS-1:0] rd_gen_raw_reg;
    logic                rd_gv_reg;
    logic [GEN_BITS-1:0] rd_gen;
    logic [GEN_BITS-1:0] gen_inc;
    logic [GEN_BITS-1:0] gen_new;

    assign rd_gen  = rd_gv_reg ? rd_gen_raw_reg : GEN_BITS'(1);
    assign gen_inc = rd_gen + 1'b1;
    // generation wraps past zero to one
    assign gen_new = (gen_inc == '0) ? GEN_BITS'(1) : gen_inc;

    always_ff @(posedge aclk) begin
        if (cmd.wr_add) begin
            rec_mem[cnt_reg] <= rec_in_reg;
        end else if (cmd.wr_upd) begin
            rec_mem[item_addr] <= rec_in_reg;
        end
        if (cmd.wr_rem) begin
            gen_mem[item_addr] <= gen_new;
        end
        if (cmd.rd_en) begin
            rd_rec_reg     <= rec_mem[rd_addr];
            rd_gen_raw_reg <= gen_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg    <= '0;
            gvalid_reg <= '0;
            count_reg  <= '0;
            rd_gv_reg  <= 1'b0;
        end else begin
            if (cmd.wr_add) begin
                occ_reg[cnt_reg] <= 1'b1;
            end
            if (cmd.wr_rem) begin
                occ_reg[item_addr]    <= 1'b0;
                gvalid_reg[item_addr] <= 1'b1;
            end
            if (cmd.rd_en) begin
                rd_gv_reg <= gvalid_reg[rd_addr];
            end
            count_reg <= count_next;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.wr_add) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.wr_rem) begin
            count_next = count_reg - 1'b1;
        end
    end

    logic live;
    assign live = (gen_reg != '0) && in_range && occ_reg[item_addr] &&
                  (32'(rd_gen) == 32'(gen_reg));

    // resolve scan, stage 0: read data of slot p0_idx
    logic             p0_v_reg;
    logic [IDX_W-1:0] p0_idx_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_v_reg <= 1'b0;
        end else begin
            p0_v_reg <= cmd.rd_en && cmd.scan_push;
        end
        p0_idx_reg <= cnt_reg;
    end

    // stage 1: containment and extents
    logic               box_ok, inside_pt, holds, cand;
    logic signed [32:0] dx_full, dz_full;
    assign box_ok = (rd_rec_reg.min_x <= rd_rec_reg.max_x) &&
                    (rd_rec_reg.min_z <= rd_rec_reg.max_z);
    assign inside_pt = (px_reg >= rd_rec_reg.min_x) && (px_reg <= rd_rec_reg.max_x) &&
                       (pz_reg >= rd_rec_reg.min_z) && (pz_reg <= rd_rec_reg.max_z);
    assign holds = !rd_rec_reg.flags[2] || (box_ok && inside_pt);
    assign cand  = occ_reg[p0_idx_reg] && (rd_rec_reg.flags[1:0] == 2'b11) && holds;
    assign dx_full = {rd_rec_reg.max_x[31], rd_rec_reg.max_x} -
                     {rd_rec_reg.min_x[31], rd_rec_reg.min_x};
    assign dz_full = {rd_rec_reg.max_z[31], rd_rec_reg.max_z} -
                     {rd_rec_reg.min_z[31], rd_rec_reg.min_z};

    logic               v1_reg, v2_reg;
    logic [IDX_W-1:0]   idx1_reg, idx2_reg;
    logic [2:0]         flags1_reg, flags2_reg;
    logic signed [15:0] prio1_reg, prio2_reg;
    logic signed [31:0] level1_reg, level2_reg;
    logic [31:0]        dx1_reg, dz1_reg;
    logic [63:0]        area2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= p0_v_reg && cand;
            v2_reg <= v1_reg;
        end
        idx1_reg   <= p0_idx_reg;
        flags1_reg <= rd_rec_reg.flags;
        prio1_reg  <= rd_rec_reg.prio;
        level1_reg <= rd_rec_reg.level;
        // extents are non-negative for any bounded candidate
        dx1_reg    <= dx_full[31:0];
        dz1_reg    <= dz_full[31:0];
        // stage 2: area
        idx2_reg   <= idx1_reg;
        flags2_reg <= flags1_reg;
        prio2_reg  <= prio1_reg;
        level2_reg <= level1_reg;
        area2_reg  <= dx1_reg * dz1_reg;
    end

    // stage 3: best region
    logic               found_reg;
    logic [2:0]         best_flags_reg;
    logic signed [15:0] best_prio_reg;
    logic signed [31:0] best_level_reg;
    logic [63:0]        best_area_reg;
    logic               tie_better, take;

    always_comb begin
        if (flags2_reg[2] != best_flags_reg[2]) begin
            tie_better = flags2_reg[2];
        end else if (flags2_reg[2]) begin
            tie_better = area2_reg < best_area_reg;
        end else begin
            tie_better = 1'b0;
        end
        take = v2_reg && (!found_reg || (prio2_reg > best_prio_reg) ||
                          ((prio2_reg == best_prio_reg) && tie_better));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
        end else if (cmd.best_clr) begin
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
        end else if (take) begin
            found_reg    <= 1'b1;
            best_idx_reg <= idx2_reg;
        end
        if (take) begin
            best_flags_reg <= flags2_reg;
            best_prio_reg  <= prio2_reg;
            best_level_reg <= level2_reg;
            best_area_reg  <= area2_reg;
        end
    end

    // result register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_ok_reg;
    logic [OUT_TDATA_W-1:0] res_data;
    logic                   res_ok;
    logic                   out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        res_data = '0;
        res_ok   = 1'b0;
        case (cmd.res_sel)
            RES_FAIL: res_ok = 1'b0;
            RES_ACK:  res_ok = 1'b1;
            RES_ADD: begin
                res_ok          = 1'b1;
                res_data[5:0]   = IDX_FW'(cnt_reg);
                res_data[21:6]  = GEN_FW'(rd_gen);
            end
            RES_GET: begin
                res_ok           = 1'b1;
                res_data[200:22] = rd_rec_reg;
            end
            RES_RESOLVE: begin
                res_ok = found_reg;
                if (found_reg) begin
                    res_data[5:0]     = IDX_FW'(best_idx_reg);
                    res_data[21:6]    = GEN_FW'(rd_gen);
                    res_data[24:22]   = best_flags_reg;
                    res_data[168:153] = best_prio_reg;
                    res_data[200:169] = best_level_reg;
                end
            end
            default: res_ok = 1'b0;
        endcase
        res_data[207:201] = CNT_FW'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.res_ld) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.res_ld) begin
            out_data_reg <= res_data;
            out_ok_reg   <= res_ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

    assign sts.kind      = kind_reg;
    assign sts.live      = live;
    assign sts.full      = (count_reg == CNT_W'(SLOTS));
    assign sts.scan_free = !occ_reg[cnt_reg];
    assign sts.scan_last = (cnt_reg == LAST_IDX);
    assign sts.pipe_busy = p0_v_reg || v1_reg || v2_reg;
    assign sts.out_free  = out_free;

endmodule
